>>> rtl/core/vep_pkg.sv
// ----------------------------------------------------------------------------
// vep_pkg
// Shared types, codes and defaults of the VT52 escape sequence parser.
// ----------------------------------------------------------------------------
package vep_pkg;

  localparam int unsigned DefaultQueueDepth = 2;

  localparam int unsigned ColW   = 7;
  localparam int unsigned RowW   = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned OpW    = 3;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ColW-1:0] DefaultLastColumn = 7'd79;
  localparam logic [RowW-1:0] DefaultLastRow    = 7'd23;

  localparam logic [CfgIdxW-1:0] RegLastColumn = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLastRow    = 1'b1;

  localparam logic [ByteW-1:0] CharNul   = 8'h00;
  localparam logic [ByteW-1:0] CharBs    = 8'h08;
  localparam logic [ByteW-1:0] CharHt    = 8'h09;
  localparam logic [ByteW-1:0] CharLf    = 8'h0A;
  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharEsc   = 8'h1B;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharSlash = 8'h2F;
  localparam logic [ByteW-1:0] CharTilde = 8'h7E;
  localparam logic [ByteW-1:0] CharA     = 8'h41;
  localparam logic [ByteW-1:0] CharB     = 8'h42;
  localparam logic [ByteW-1:0] CharC     = 8'h43;
  localparam logic [ByteW-1:0] CharD     = 8'h44;
  localparam logic [ByteW-1:0] CharH     = 8'h48;
  localparam logic [ByteW-1:0] CharI     = 8'h49;
  localparam logic [ByteW-1:0] CharJ     = 8'h4A;
  localparam logic [ByteW-1:0] CharK     = 8'h4B;
  localparam logic [ByteW-1:0] CharY     = 8'h59;
  localparam logic [ByteW-1:0] CharZ     = 8'h5A;

  typedef enum logic [OpW-1:0] {
    OpSetCur  = 3'd0,
    OpPutCh   = 3'd1,
    OpScrUp   = 3'd2,
    OpScrDn   = 3'd3,
    OpClrEol  = 3'd4,
    OpClrRows = 3'd5,
    OpReply   = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    EscNormal = 2'd0,
    EscSeen   = 2'd1,
    EscRow    = 2'd2,
    EscCol    = 2'd3
  } esc_e;

  typedef enum logic [2:0] {
    KindSetCur,
    KindPutCh,
    KindScrUp,
    KindScrDn,
    KindClrEol,
    KindClrJ,
    KindReply
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [ColW-1:0]  old_col;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [ByteW-1:0] value;
  } pkt_t;

endpackage

>>> rtl/core/vep_if.sv
// ----------------------------------------------------------------------------
// vep_if
// Valid/ready channels of the parser: received bytes, commands, register writes.
// ----------------------------------------------------------------------------
interface vep_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface vep_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [6:0] col;
  logic [6:0] row;
  logic [7:0] value;
  logic       last;
  modport source (output valid, output op, output col, output row, output value,
                  output last, input ready);
  modport sink (input valid, input op, input col, input row, input value,
                input last, output ready);
endinterface

interface vep_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/vep_front.sv
// ----------------------------------------------------------------------------
// vep_front
// Byte decoder: escape state, cursor, screen size; up to one packet per byte.
// ----------------------------------------------------------------------------
module vep_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  vep_rx_if.sink        rx_i,
  vep_cfg_if.sink       cfg_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output vep_pkg::pkt_t push_pkt_o
);

  vep_pkg::esc_e esc_q, esc_d;
  logic [vep_pkg::ColW-1:0] col_q, col_d, last_col_q;
  logic [vep_pkg::RowW-1:0] row_q, row_d, latch_q, latch_d, last_row_q;
  logic [vep_pkg::ByteW-1:0] b;
  logic printable, push_en, accept;
  vep_pkg::kind_e kind;
  logic [7:0] col_inc, row_inc, tab_col, y_col;

  assign b         = rx_i.rx_byte;
  assign rx_i.ready = push_ready_i;
  assign accept    = rx_i.valid && push_ready_i;
  assign cfg_i.ready = 1'b1;
  assign printable = b inside {[vep_pkg::CharSpace:vep_pkg::CharTilde]};

  assign col_inc = {1'b0, col_q} + 8'd1;
  assign row_inc = {1'b0, row_q} + 8'd1;
  assign tab_col = {1'b0, col_q[6:3], 3'b000} + 8'd8;
  assign y_col   = b - vep_pkg::CharSpace;

  always_comb begin
    esc_d   = esc_q;
    col_d   = col_q;
    row_d   = row_q;
    latch_d = latch_q;
    kind    = vep_pkg::KindSetCur;
    push_en = 1'b1;
    if (b == vep_pkg::CharNul) begin
      push_en = 1'b0;
    end else if (printable && esc_q != vep_pkg::EscSeen) begin
      case (esc_q)
        vep_pkg::EscNormal: begin
          kind  = vep_pkg::KindPutCh;
          col_d = (col_inc > {1'b0, last_col_q}) ? '0 : col_inc[6:0];
        end
        vep_pkg::EscRow: begin
          latch_d = y_col[6:0];
          esc_d   = vep_pkg::EscCol;
          push_en = 1'b0;
        end
        default: begin
          col_d = (y_col > {1'b0, last_col_q}) ? last_col_q : y_col[6:0];
          row_d = (latch_q > last_row_q) ? last_row_q : latch_q;
          esc_d = vep_pkg::EscNormal;
        end
      endcase
    end else begin
      case (b)
        vep_pkg::CharCr: col_d = '0;
        vep_pkg::CharLf: begin
          if (row_inc > {1'b0, last_row_q}) begin
            row_d = last_row_q;
            kind  = vep_pkg::KindScrUp;
          end else begin
            row_d = row_inc[6:0];
          end
        end
        vep_pkg::CharBs: if (col_q != '0) col_d = col_q - 7'd1;
        vep_pkg::CharHt: col_d = (tab_col > {1'b0, last_col_q}) ? last_col_q : tab_col[6:0];
        vep_pkg::CharEsc: esc_d = vep_pkg::EscSeen;
        vep_pkg::CharA: begin
          esc_d = vep_pkg::EscNormal;
          if (row_q != '0) row_d = row_q - 7'd1;
        end
        vep_pkg::CharB: begin
          esc_d = vep_pkg::EscNormal;
          if (row_q < last_row_q) row_d = row_inc[6:0];
        end
        vep_pkg::CharC: begin
          esc_d = vep_pkg::EscNormal;
          if (col_q < last_col_q) col_d = col_inc[6:0];
        end
        vep_pkg::CharD: begin
          esc_d = vep_pkg::EscNormal;
          if (col_q != '0) col_d = col_q - 7'd1;
        end
        vep_pkg::CharH: begin
          esc_d = vep_pkg::EscNormal;
          col_d = '0;
          row_d = '0;
        end
        vep_pkg::CharI: begin
          esc_d = vep_pkg::EscNormal;
          if (row_q != '0) row_d = row_q - 7'd1;
          else kind = vep_pkg::KindScrDn;
        end
        vep_pkg::CharJ: begin
          esc_d = vep_pkg::EscNormal;
          kind  = (row_q < last_row_q) ? vep_pkg::KindClrJ : vep_pkg::KindClrEol;
        end
        vep_pkg::CharK: begin
          esc_d = vep_pkg::EscNormal;
          kind  = vep_pkg::KindClrEol;
        end
        vep_pkg::CharY: esc_d = vep_pkg::EscRow;
        vep_pkg::CharZ: begin
          esc_d = vep_pkg::EscNormal;
          kind  = vep_pkg::KindReply;
        end
        default: if (printable) esc_d = vep_pkg::EscNormal;
      endcase
    end
  end

  assign push_valid_o       = rx_i.valid && push_en;
  assign push_pkt_o.kind    = kind;
  assign push_pkt_o.old_col = col_q;
  assign push_pkt_o.col     = col_d;
  assign push_pkt_o.row     = row_d;
  assign push_pkt_o.value   = (kind == vep_pkg::KindPutCh) ? b : {1'b0, last_row_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= vep_pkg::EscNormal;
      col_q   <= '0;
      row_q   <= '0;
      latch_q <= '0;
    end else if (accept) begin
      esc_q   <= esc_d;
      col_q   <= col_d;
      row_q   <= row_d;
      latch_q <= latch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= vep_pkg::DefaultLastColumn;
      last_row_q <= vep_pkg::DefaultLastRow;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        vep_pkg::RegLastColumn: last_col_q <= cfg_i.data;
        vep_pkg::RegLastRow:    last_row_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/vep_fifo.sv
// ----------------------------------------------------------------------------
// vep_fifo
// Short packet queue between decoder and command sequencer.
// ----------------------------------------------------------------------------
module vep_fifo #(
  parameter int unsigned Depth = vep_pkg::DefaultQueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  vep_pkg::pkt_t push_pkt_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output vep_pkg::pkt_t pop_pkt_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  vep_pkg::pkt_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_pkt_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_pkt_i;
  end

endmodule

>>> rtl/core/vep_back.sv
// ----------------------------------------------------------------------------
// vep_back
// Command sequencer: expands one packet into one to four command words.
// ----------------------------------------------------------------------------
module vep_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  vep_pkg::pkt_t pop_pkt_i,
  vep_cmd_if.source     cmd_o
);

  logic [1:0] step_q, fin;
  logic load, is_last;
  vep_pkg::op_e op;
  logic [vep_pkg::ColW-1:0] col;
  logic [vep_pkg::RowW-1:0] row;
  logic [vep_pkg::ByteW-1:0] value;
  logic valid_q, last_q;
  vep_pkg::op_e op_q;
  logic [vep_pkg::ColW-1:0] col_q;
  logic [vep_pkg::RowW-1:0] row_q;
  logic [vep_pkg::ByteW-1:0] value_q;

  always_comb begin
    case (pop_pkt_i.kind)
      vep_pkg::KindSetCur: fin = 2'd0;
      vep_pkg::KindClrJ:   fin = 2'd2;
      vep_pkg::KindReply:  fin = 2'd3;
      default:             fin = 2'd1;
    endcase
  end

  assign is_last = step_q == fin;

  always_comb begin
    op    = vep_pkg::OpSetCur;
    col   = pop_pkt_i.col;
    row   = pop_pkt_i.row;
    value = '0;
    if (!is_last) begin
      case (pop_pkt_i.kind)
        vep_pkg::KindPutCh: begin
          op    = vep_pkg::OpPutCh;
          col   = pop_pkt_i.old_col;
          value = pop_pkt_i.value;
        end
        vep_pkg::KindScrUp: begin
          op  = vep_pkg::OpScrUp;
          col = '0;
          row = '0;
        end
        vep_pkg::KindScrDn: begin
          op  = vep_pkg::OpScrDn;
          col = '0;
          row = '0;
        end
        vep_pkg::KindClrEol: op = vep_pkg::OpClrEol;
        vep_pkg::KindClrJ: begin
          if (step_q == 2'd0) begin
            op = vep_pkg::OpClrEol;
          end else begin
            op    = vep_pkg::OpClrRows;
            col   = '0;
            row   = pop_pkt_i.row + 7'd1;
            value = pop_pkt_i.value;
          end
        end
        vep_pkg::KindReply: begin
          op  = vep_pkg::OpReply;
          col = '0;
          row = '0;
          case (step_q)
            2'd0:    value = vep_pkg::CharEsc;
            2'd1:    value = vep_pkg::CharSlash;
            default: value = vep_pkg::CharK;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign load        = pop_valid_i && (!valid_q || cmd_o.ready);
  assign pop_ready_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      step_q  <= is_last ? 2'd0 : step_q + 2'd1;
    end else if (cmd_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q    <= op;
      col_q   <= col;
      row_q   <= row;
      value_q <= value;
      last_q  <= is_last;
    end
  end

  assign cmd_o.valid = valid_q;
  assign cmd_o.op    = op_q;
  assign cmd_o.col   = col_q;
  assign cmd_o.row   = row_q;
  assign cmd_o.value = value_q;
  assign cmd_o.last  = last_q;

endmodule

>>> rtl/core/vt52_escape_parser_top.sv
// ----------------------------------------------------------------------------
// vt52_escape_parser_top
// VT52 escape sequence parser with cursor tracking, emitting screen commands.
// ----------------------------------------------------------------------------
// rx_i  : received bytes, one word per byte; a zero byte is dropped.
// cmd_o : command words (op, col, row, value); last marks the final word of
//         the byte that caused them. Each byte yields at most four words.
// cfg_i : register writes, index 0 last_column, index 1 last_row; always
//         ready. They must be written only while the block is idle (unenforced).
// The decoder takes one byte per cycle while its packet queue has room.
// The sequencer issues one command word per cycle while cmd_o is ready,
// a byte's words in turn (four at most, for ESC Z); the sequencer sets the
// sustained rate. With an empty queue the first word of a byte passes the
// queue and the sequencer's output register before it shows on cmd_o.
// A stall on cmd_o holds the current word, fills the queue, then drops
// rx_i.ready. Reset clears the cursor, the escape state and the queue and
// loads last_column 79 and last_row 23.
// ----------------------------------------------------------------------------
module vt52_escape_parser_top #(
  parameter int unsigned QueueDepth = vep_pkg::DefaultQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vep_rx_if.sink    rx_i,
  vep_cfg_if.sink   cfg_i,
  vep_cmd_if.source cmd_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  vep_pkg::pkt_t push_pkt, pop_pkt;

  vep_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .cfg_i       (cfg_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_pkt_o  (push_pkt)
  );

  vep_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_pkt_i  (push_pkt),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_pkt_o   (pop_pkt)
  );

  vep_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_pkt_i  (pop_pkt),
    .cmd_o      (cmd_o)
  );

endmodule

>>> rtl/core/vep_checker.sv
// ----------------------------------------------------------------------------
// vep_checker
// Port-level checks on the command channel of the parser.
// ----------------------------------------------------------------------------
module vep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [2:0] op_i,
  input logic [6:0] col_i,
  input logic [6:0] row_i,
  input logic [7:0] value_i,
  input logic       last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("command word dropped while stalled");

  a_hold_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> $stable({op_i, col_i, row_i, value_i, last_i}))
    else $error("command word changed while stalled");

  a_last_setcur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (last_i == (op_i == vep_pkg::OpSetCur)))
    else $error("last flag not on the closing set-cursor word");

  a_putch_then_setcur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && op_i == vep_pkg::OpPutCh |=> valid_i && op_i == vep_pkg::OpSetCur)
    else $error("put char not followed at once by set cursor");

  a_clrrows_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && op_i == vep_pkg::OpClrRows |-> row_i != 7'd0)
    else $error("clear rows starts at row zero");

endmodule

bind vt52_escape_parser_top vep_checker u_vep_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .valid_i(cmd_o.valid),
  .ready_i(cmd_o.ready),
  .op_i   (cmd_o.op),
  .col_i  (cmd_o.col),
  .row_i  (cmd_o.row),
  .value_i(cmd_o.value),
  .last_i (cmd_o.last)
);

>>> dv/vt52_escape_parser_top_tb.sv
// ----------------------------------------------------------------------------
// vt52_escape_parser_top_tb
// Self-checking bench for the VT52 escape sequence parser.
// Streams directed bytes, then random text, controls, escape commands and
// cursor-addressing sequences over several screen sizes, with random gaps on
// the byte side and random stalls on the command side. A cursor tracker
// predicts every command word; each word taken from the block is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vt52_escape_parser_top_tb;
  import vep_pkg::*;

  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned PhaseBytes    = 28;
  localparam int unsigned NumDirected   = 26;

  localparam logic [ByteW-1:0] CharF = 8'h46;
  localparam logic [ByteW-1:0] CharG = 8'h47;

  typedef struct {
    op_e              op;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [ByteW-1:0] value;
    logic             last;
  } cmd_word_t;

  class screen_cmd_board;
    logic [ColW-1:0] last_col;
    logic [RowW-1:0] last_row;
    logic [RowW-1:0] latch_row;
    logic [ColW-1:0] cur_col;
    logic [RowW-1:0] cur_row;
    esc_e            esc;
    cmd_word_t       due_cmds[$];
    int unsigned     errors;

    function new();
      last_col  = DefaultLastColumn;
      last_row  = DefaultLastRow;
      latch_row = '0;
      cur_col   = '0;
      cur_row   = '0;
      esc       = EscNormal;
      errors    = 0;
    endfunction

    function void note_write(logic idx, logic [6:0] data);
      if (idx == RegLastColumn) last_col = data;
      else last_row = data;
    endfunction

    function void add(op_e op, int col, int row, int val);
      cmd_word_t w;
      w.op    = op;
      w.col   = 7'(col);
      w.row   = 7'(row);
      w.value = 8'(val);
      w.last  = 1'b0;
      due_cmds.push_back(w);
    endfunction

    function void take_byte(logic [ByteW-1:0] b);
      int x;
      int y;
      int w;
      int h;
      int n0;
      bit printable;
      if (b == CharNul) return;
      x = cur_col;
      y = cur_row;
      w = last_col;
      h = last_row;
      n0 = due_cmds.size();
      printable = (b >= CharSpace) && (b <= CharTilde);
      if (printable && esc != EscSeen) begin
        if (esc == EscNormal) begin
          add(OpPutCh, x, y, b);
          x++;
          if (x > w) x = 0;
          add(OpSetCur, x, y, 0);
        end else if (esc == EscRow) begin
          latch_row = 7'(b - CharSpace);
          esc = EscCol;
        end else begin
          x = b - CharSpace;
          y = latch_row;
          if (x > w) x = w;
          if (y > h) y = h;
          add(OpSetCur, x, y, 0);
          esc = EscNormal;
        end
      end else begin
        case (b)
          CharCr: x = 0;
          CharLf: begin
            y++;
            if (y > h) begin
              y = h;
              add(OpScrUp, 0, 0, 0);
            end
          end
          CharBs: if (x > 0) x--;
          CharHt: begin
            x = x + 8 - (x % 8);
            if (x > w) x = w;
          end
          CharEsc: esc = EscSeen;
          CharA: begin
            esc = EscNormal;
            if (y > 0) y--;
          end
          CharB: begin
            esc = EscNormal;
            if (y < h) y++;
          end
          CharC: begin
            esc = EscNormal;
            if (x < w) x++;
          end
          CharD: begin
            esc = EscNormal;
            if (x > 0) x--;
          end
          CharH: begin
            esc = EscNormal;
            x = 0;
            y = 0;
          end
          CharI: begin
            esc = EscNormal;
            if (y > 0) y--;
            else add(OpScrDn, 0, 0, 0);
          end
          CharJ: begin
            esc = EscNormal;
            add(OpClrEol, x, y, 0);
            if (y < h) add(OpClrRows, 0, y + 1, h);
          end
          CharK: begin
            esc = EscNormal;
            add(OpClrEol, x, y, 0);
          end
          CharY: esc = EscRow;
          CharZ: begin
            esc = EscNormal;
            add(OpReply, 0, 0, CharEsc);
            add(OpReply, 0, 0, CharSlash);
            add(OpReply, 0, 0, CharK);
          end
          default: if (printable) esc = EscNormal;
        endcase
        add(OpSetCur, x, y, 0);
      end
      cur_col = 7'(x);
      cur_row = 7'(y);
      if (due_cmds.size() > n0) due_cmds[due_cmds.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_cmd(logic [OpW-1:0] op, logic [ColW-1:0] col, logic [RowW-1:0] row,
                   logic [ByteW-1:0] value, logic last);
      cmd_word_t e;
      if (due_cmds.size() == 0) begin
        report($sformatf("unexpected word op=%0d col=%0d row=%0d value=%0h last=%0b",
                         op, col, row, value, last));
        return;
      end
      e = due_cmds.pop_front();
      if (op !== e.op || col !== e.col || row !== e.row || value !== e.value ||
          last !== e.last)
        report($sformatf("got op=%0d col=%0d row=%0d value=%0h last=%0b, want %0d %0d %0d %0h %0b",
                         op, col, row, value, last, e.op, e.col, e.row, e.value, e.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  vep_rx_if  rx_ch ();
  vep_cfg_if cfg_ch ();
  vep_cmd_if cmd_ch ();

  vt52_escape_parser_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .cfg_i  (cfg_ch),
    .cmd_o  (cmd_ch)
  );

  screen_cmd_board sb;
  int unsigned     stall_left;
  int unsigned     idle_cycles;
  bit              no_idle;
  logic [ByteW-1:0] directed_bytes [NumDirected];
  int              phase_cols [NumPhases] = '{127, 1, 127, 1, 0, 0, 79};
  int              phase_rows [NumPhases] = '{127, 1, 1, 127, 0, 0, 23};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      cmd_ch.ready = 1'b0;
      stall_left--;
    end else begin
      cmd_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sb.check_cmd(cmd_ch.op, cmd_ch.col, cmd_ch.row, cmd_ch.value, cmd_ch.last);
        stall_left = no_idle ? 0 : $urandom_range(13);
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (rx_ch.valid && rx_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("** vt52_escape_parser_top: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(13);
    @(negedge clk);
    if (gap > 0) begin
      rx_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   = 1'b1;
    rx_ch.rx_byte = b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.take_byte(b);
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.note_write(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // drop the byte stream and wait for every predicted word, plus the tail
  task automatic settle();
    @(negedge clk);
    rx_ch.valid = 1'b0;
    while (sb.due_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [ByteW-1:0] any_text();
    return 8'($urandom_range(CharSpace, CharTilde));
  endfunction

  function automatic logic [ByteW-1:0] any_control();
    case ($urandom_range(3))
      0: return CharCr;
      1: return CharLf;
      2: return CharBs;
      default: return CharHt;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] any_esc_cmd();
    case ($urandom_range(13))
      0: return CharA;
      1: return CharB;
      2: return CharC;
      3: return CharD;
      4: return CharH;
      5: return CharI;
      6: return CharJ;
      7: return CharK;
      8: return CharY;
      9: return CharZ;
      10: return CharF;
      11: return CharG;
      default: return any_text();
    endcase
  endfunction

  // mostly on screen, sometimes anywhere in the printable range
  function automatic logic [ByteW-1:0] coord(int unsigned lim);
    if ($urandom_range(3) == 0) return any_text();
    return 8'(CharSpace + $urandom_range(0, lim < 94 ? lim : 94));
  endfunction

  function automatic logic [6:0] size_for(int v);
    return (v != 0) ? 7'(v) : 7'($urandom_range(1, 127));
  endfunction

  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    logic [ByteW-1:0] b;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(any_text());
          sent++;
        end
      end else if (pick < 45) begin
        send_byte(any_control());
        sent++;
      end else if (pick < 65) begin
        send_byte(CharEsc);
        send_byte(any_esc_cmd());
        sent += 2;
      end else if (pick < 80) begin
        send_byte(CharEsc);
        send_byte(CharY);
        send_byte(coord(sb.last_row));
        send_byte(coord(sb.last_col));
        sent += 4;
      end else if (pick < 90) begin
        send_byte(CharEsc);
        send_byte(CharY);
        sent += 2;
        case ($urandom_range(2))
          0: begin
            send_byte(any_control());
            send_byte(coord(sb.last_row));
            send_byte(any_control());
            send_byte(coord(sb.last_col));
            sent += 4;
          end
          1: begin
            send_byte(CharEsc);
            send_byte(CharY);
            send_byte(coord(sb.last_row));
            send_byte(coord(sb.last_col));
            sent += 4;
          end
          default: begin
            send_byte(coord(sb.last_row));
            sent++;
          end
        endcase
      end else begin
        b = 8'($urandom_range(255));
        send_byte(b);
        if (b != CharNul) sent++;
      end
    end
  endtask

  initial begin
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = RegLastColumn;
    cfg_ch.data    = '0;
    cmd_ch.ready   = 1'b0;
    stall_left     = 0;
    idle_cycles    = 0;
    no_idle        = 1'b0;
    sb             = new();
    directed_bytes = '{CharSpace, CharTilde, 8'hFF, 8'h7F, CharNul, CharBs, CharCr, CharBs,
                       CharHt, CharEsc, CharI, CharEsc, CharY, CharTilde, CharTilde, CharLf,
                       CharEsc, CharJ, CharEsc, CharA, CharEsc, CharJ, CharEsc, CharZ,
                       CharEsc, CharK};
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    for (int p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(RegLastColumn, size_for(phase_cols[p]));
      write_reg(RegLastRow, size_for(phase_rows[p]));
      no_idle = (p % 3 == 2);
      random_traffic(PhaseBytes);
    end
    settle();

    if (sb.errors == 0) begin
      $display("** vt52_escape_parser_top: PASSED **");
    end else begin
      $display("** vt52_escape_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/vep_pkg.sv
rtl/core/vep_if.sv
rtl/core/vep_front.sv
rtl/core/vep_fifo.sv
rtl/core/vep_back.sv
rtl/core/vt52_escape_parser_top.sv
rtl/core/vep_checker.sv
dv/vt52_escape_parser_top_tb.sv
